### design/fdi_pkg.sv
package fdi_pkg;

  // Fixed geometry of the index
  localparam int BUCKET_COUNT    = 256;
  localparam int BUCKET_W        = 8;
  localparam int FILL_W          = 4;
  localparam int HIT_W           = 16;
  localparam int STATUS_W        = 2;

  // Defaults for the top-level parameters
  localparam int DEF_BUCKET_WAYS = 8;
  localparam int DEF_KEY_BYTES   = 6;

  // Hand-over queues (depth must be a power of two)
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW  = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

endpackage

### design/fdi_front.sv
module fdi_front import fdi_pkg::*; #(
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [8*KEY_BYTES-1:0]     in_fingerprint,
  output logic                       in_full,
  output logic                       req_valid,
  input  logic                       req_ready,
  output logic [BUCKET_W-1:0]        req_bucket,
  output logic [8*(KEY_BYTES-1)-1:0] req_rest
);

  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int REST_W = 8 * (KEY_BYTES - 1);

  logic [BUCKET_W-1:0] q_bucket_r [QUEUE_DEPTH];
  logic [REST_W-1:0]   q_rest_r   [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push_ok;
  logic                pop_ok;

  assign in_full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign req_valid  = (cnt_r != '0);
  assign req_bucket = q_bucket_r[rd_ptr_r];
  assign req_rest   = q_rest_r[rd_ptr_r];

  assign push_ok = in_push && !in_full;
  assign pop_ok  = req_valid && req_ready;

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Split the key: top byte picks the bucket, the rest is compared
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_bucket_r[wr_ptr_r] <= in_fingerprint[KEY_W-1 -: BUCKET_W];
      q_rest_r[wr_ptr_r]   <= in_fingerprint[REST_W-1:0];
    end
  end

endmodule

### design/fdi_back.sv
module fdi_back import fdi_pkg::*; #(
  parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [BUCKET_W-1:0]        req_bucket,
  input  logic [8*(KEY_BYTES-1)-1:0] req_rest,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [STATUS_W-1:0]        out_status,
  output logic [HIT_W-1:0]           out_hit_count
);

  localparam int REST_W  = 8 * (KEY_BYTES - 1);
  localparam int ENTRY_W = REST_W + HIT_W;
  localparam int ROW_W   = BUCKET_WAYS * ENTRY_W;

  // Bucket rows: entry w holds {key, hits} at [w*ENTRY_W +: ENTRY_W]
  logic [ROW_W-1:0]    row_mem  [BUCKET_COUNT];
  logic [FILL_W-1:0]   fill_mem [BUCKET_COUNT];
  logic                fill_vld_r [BUCKET_COUNT];

  bk_state_t           state_r, state_nxt;
  logic [BUCKET_W-1:0] bucket_r;
  logic [REST_W-1:0]   rest_r;
  logic [ROW_W-1:0]    row_q_r;
  logic [FILL_W-1:0]   fill_q_r;
  logic                vld_q_r;

  logic                rd_en;
  logic                upd;
  logic                room;
  logic [FILL_W-1:0]   fill_cur;
  logic [BUCKET_WAYS-1:0] match;
  logic                hit_any;
  logic                is_full;
  logic [HIT_W-1:0]    hits_sel;
  logic [HIT_W-1:0]    hits_inc;
  logic [ROW_W-1:0]    row_wdata;
  logic [FILL_W-1:0]   fill_wdata;
  logic                row_we;
  logic                fill_we;
  status_t             res_status;
  logic [HIT_W-1:0]    res_hits;

  // Result queue
  status_t             oq_status_r [QUEUE_DEPTH];
  logic [HIT_W-1:0]    oq_hits_r   [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   oq_wr_r, oq_wr_nxt;
  logic [QPTR_W-1:0]   oq_rd_r, oq_rd_nxt;
  logic [QCNT_W-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic                oq_pop;

  assign room = (oq_cnt_r != QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (req_valid && room) state_nxt = BK_UPDATE;
      BK_UPDATE: state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    upd       = 1'b0;
    unique case (state_r)
      BK_IDLE:   req_ready = room;
      BK_UPDATE: upd = 1'b1;
      default:   req_ready = 1'b0;
    endcase
  end

  assign rd_en = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Read the bucket row as the item is taken
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q_r  <= row_mem[req_bucket];
      fill_q_r <= fill_mem[req_bucket];
      vld_q_r  <= fill_vld_r[req_bucket];
      bucket_r <= req_bucket;
      rest_r   <= req_rest;
    end
  end

  // Compare all ways at once; stored keys are unique so at most one matches
  always_comb begin
    fill_cur = vld_q_r ? fill_q_r : '0;
    hits_sel = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      match[w] = (FILL_W'(w) < fill_cur) &&
                 (row_q_r[w*ENTRY_W+HIT_W +: REST_W] == rest_r);
      hits_sel = hits_sel | (match[w] ? row_q_r[w*ENTRY_W +: HIT_W] : '0);
    end
    hit_any  = |match;
    is_full  = (fill_cur >= FILL_W'(BUCKET_WAYS));
    hits_inc = (hits_sel == HIT_MAX) ? hits_sel : hits_sel + 1'b1;

    row_wdata = row_q_r;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (match[w]) begin
        row_wdata[w*ENTRY_W +: HIT_W] = hits_inc;
      end else if (!hit_any && FILL_W'(w) == fill_cur) begin
        row_wdata[w*ENTRY_W+HIT_W +: REST_W] = rest_r;
        row_wdata[w*ENTRY_W +: HIT_W]        = '0;
      end
    end
    fill_wdata = fill_cur + 1'b1;

    row_we  = upd && (hit_any || !is_full);
    fill_we = upd && !hit_any && !is_full;

    if (hit_any) begin
      res_status = ST_DUP;
      res_hits   = hits_inc;
    end else if (is_full) begin
      res_status = ST_FULL;
      res_hits   = '0;
    end else begin
      res_status = ST_NEW;
      res_hits   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[bucket_r] <= row_wdata;
    end
    if (fill_we) begin
      fill_mem[bucket_r] <= fill_wdata;
    end
  end

  // Per-bucket valid bits: an unmarked bucket reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        fill_vld_r[b] <= 1'b0;
      end
    end else if (fill_we) begin
      fill_vld_r[bucket_r] <= 1'b1;
    end
  end

  // Result queue
  assign out_empty     = (oq_cnt_r == '0);
  assign out_status    = oq_status_r[oq_rd_r];
  assign out_hit_count = oq_hits_r[oq_rd_r];
  assign oq_pop        = out_pop && !out_empty;

  always_comb begin
    oq_wr_nxt  = upd ? oq_wr_r + 1'b1 : oq_wr_r;
    oq_rd_nxt  = oq_pop ? oq_rd_r + 1'b1 : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + QCNT_W'(upd) - QCNT_W'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      oq_status_r[oq_wr_r] <= res_status;
      oq_hits_r[oq_wr_r]   <= res_hits;
    end
  end

endmodule

### design/fingerprint_dedup_index_core.sv
// Fingerprint de-duplication index: insert-if-absent set of chunk keys in
// BUCKET_COUNT buckets of BUCKET_WAYS entries each.
// Input queue: drive in_fingerprint and raise in_push; the transfer happens on
//   an edge where in_push is high and in_full is low. The top key byte picks
//   the bucket, the remaining bytes are the stored key.
// Result queue: while out_empty is low, out_status (new, duplicate, bucket
//   full) and out_hit_count of the oldest result are valid; raise out_pop to
//   take it. Exactly one result per item, in input order.
// Path: the transfer edge writes the input queue, then the bucket row read is
//   registered as the back end takes the item, and the compare and write-back
//   of the update state pushes the result.
// Pacing: the back end takes no new item until the last one is through, as
//   the read-modify-write of the bucket row memory takes each item through a
//   read step and an update step before the next bucket read.
// Reset: empties both queues and clears the per-bucket valid bits, so every
//   bucket starts empty at once; no clearing pass is needed.
// Stall: when out_pop stays low the result queue fills, the back end holds,
//   then the input queue fills and in_full rises. Nothing is lost.
module fingerprint_dedup_index_core import fdi_pkg::*; #(
  parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic [8*KEY_BYTES-1:0] in_fingerprint,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [STATUS_W-1:0]    out_status,
  output logic [HIT_W-1:0]       out_hit_count
);

  localparam int REST_W = 8 * (KEY_BYTES - 1);

  // Hand-over between front (accept and split) and back (lookup and update)
  logic                req_valid;
  logic                req_ready;
  logic [BUCKET_W-1:0] req_bucket;
  logic [REST_W-1:0]   req_rest;

  fdi_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_fingerprint (in_fingerprint),
    .in_full        (in_full),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req_bucket     (req_bucket),
    .req_rest       (req_rest)
  );

  fdi_back #(
    .BUCKET_WAYS (BUCKET_WAYS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_bucket    (req_bucket),
    .req_rest      (req_rest),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_hit_count (out_hit_count)
  );

endmodule
